>>> rtl/sorted_key_value_write_buffer_defines.svh
// ----------------------------------------------------------------------------
// sorted key-value write buffer: assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_WRITE_BUFFER_DEFINES_SVH
`define SORTED_KEY_VALUE_WRITE_BUFFER_DEFINES_SVH

// condition that must hold at every clock edge
`define SKVWB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SKVWB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKVWB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/skvwb_pkg.sv
// ----------------------------------------------------------------------------
// skvwb_pkg
// types, codes and sizes shared by the write buffer and its cells
// ----------------------------------------------------------------------------
package skvwb_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TOTAL_W  = 7;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;

    localparam logic [TOTAL_W-1:0] CAP_LIMIT         = TOTAL_W'(CAPACITY);
    localparam logic [TOTAL_W-1:0] FILL_LIMIT_RESET  = 7'd32;
    localparam logic [KEY_W-1:0]   SIGN_FLIP         = {1'b1, {(KEY_W-1){1'b0}}};

    // request kinds
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_GET   = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;

    // result status codes
    localparam logic [2:0] STS_INSERTED = 3'd0;
    localparam logic [2:0] STS_UPDATED  = 3'd1;
    localparam logic [2:0] STS_REJECTED = 3'd2;
    localparam logic [2:0] STS_LIVE     = 3'd3;
    localparam logic [2:0] STS_TOMB     = 3'd4;
    localparam logic [2:0] STS_MISS     = 3'd5;
    localparam logic [2:0] STS_DRAINED  = 3'd6;
    localparam logic [2:0] STS_EMPTY    = 3'd7;

    // cell operations
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_LOOK   = 3'd1;
    localparam logic [2:0] CELL_UPDATE = 3'd2;
    localparam logic [2:0] CELL_INSERT = 3'd3;
    localparam logic [2:0] CELL_DRAIN  = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             tomb;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [2:0] op;
        entry_t     req;
    } cell_ctrl_t;

endpackage

>>> rtl/skvwb_cell.sv
// ----------------------------------------------------------------------------
// skvwb_cell
// one slot of the sorted chain: holds an entry, compares against the
// broadcast key and shifts right on insert or left on drain
// ----------------------------------------------------------------------------
module skvwb_cell (
    input  logic                clk,
    input  skvwb_pkg::cell_ctrl_t ctrl,
    input  logic                occ,
    input  logic                left_less,
    input  skvwb_pkg::entry_t   left_ent,
    input  skvwb_pkg::entry_t   right_ent,
    output skvwb_pkg::entry_t   ent,
    output skvwb_pkg::entry_t   hit_ent,
    output logic                less,
    output logic                eq
);
    import skvwb_pkg::*;

    entry_t ent_reg;
    logic   less_reg;
    logic   eq_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            CELL_LOOK:
            begin
                // signed compare by flipping the sign bits
                less_reg <= occ && ((ent_reg.key ^ SIGN_FLIP) < (ctrl.req.key ^ SIGN_FLIP));
                eq_reg   <= occ && (ent_reg.key == ctrl.req.key);
            end
            CELL_UPDATE:
            begin
                if (eq_reg)
                begin
                    ent_reg <= ctrl.req;
                end
            end
            CELL_INSERT:
            begin
                if (!less_reg)
                begin
                    ent_reg <= left_less ? ctrl.req : left_ent;
                end
            end
            CELL_DRAIN:
            begin
                ent_reg <= right_ent;
            end
            default:
            begin
            end
        endcase
    end

    assign ent     = ent_reg;
    assign hit_ent = eq_reg ? ent_reg : '0;
    assign less    = less_reg;
    assign eq      = eq_reg;

endmodule

>>> rtl/sorted_key_value_write_buffer.sv
// ----------------------------------------------------------------------------
// sorted_key_value_write_buffer
// key-ordered write buffer built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// channel   direction  transfer moves
// s_*       in         one request: type, key, value, tombstone
// m_*       out        one result: status, key, value, tombstone, count, full, last
// cfg_*     in         fill limit register write
//
// a put or get passes S_LOOK (broadcast compare in every cell) and then S_ACT
// (update, insert shift and result), where its result is registered; the next
// request is taken back in S_IDLE; req_type 3 is dropped in the cycle that
// takes it; a drain of n entries puts out one result per cycle while the
// receiver does not stall (the chain shifts left by one cell per transfer)
// reset clears the count, the drain remainder, the state and the output valid
// and loads the fill limit reset value; cell contents are only read below the
// count or the drain remainder and need no reset
// a stalled m_tready holds the result register and the controller; a new
// request is taken while the last result waits
// ----------------------------------------------------------------------------
module sorted_key_value_write_buffer (
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // key[63:0], value[127:64], tombstone[128], zero pad
    input  logic [1:0]   s_tuser,  // req_type
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,  // out_key[63:0], out_value[127:64], out_tombstone[128],
                                   // entry_total[135:129], is_full[136], zero pad
    output logic [2:0]   m_tuser,  // status
    output logic         m_tlast,  // last
    // fill limit write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);
    import skvwb_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_ACT   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    // control state
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0] fill_limit_reg;
    logic               out_valid_reg, out_valid_next;

    // request held for the compare and the update
    logic [1:0]         req_type_reg;
    entry_t             req_reg;

    // result register
    logic [2:0]         out_status_reg, out_status_next;
    entry_t             out_ent_reg, out_ent_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_full_reg, out_full_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;

    logic               in_xfer;
    logic               out_free;
    logic [TOTAL_W-1:0] eff_limit;
    logic [TOTAL_W-1:0] count_ext;
    logic               at_limit;

    // chain signals
    cell_ctrl_t          ctrl;
    entry_t              cell_ent [CAPACITY];
    entry_t              cell_hit [CAPACITY];
    logic [CAPACITY-1:0] cell_less;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_occ;
    entry_t              hit_ent;
    logic                hit;

    // check terms
    logic                out_is_drain;
    logic                act_stalled;
    logic                drain_moves;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign eff_limit = (fill_limit_reg < CAP_LIMIT) ? fill_limit_reg : CAP_LIMIT;
    assign count_ext = TOTAL_W'(count_reg);
    assign at_limit  = (count_ext >= eff_limit);

    // ---------------------------------------------------------------- chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic   l_less;
            entry_t l_ent;
            entry_t r_ent;

            assign cell_occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                // the head cell takes the new entry whenever it is not below it
                assign l_less = 1'b1;
                assign l_ent  = '0;
            end
            else
            begin : g_body
                assign l_less = cell_less[gi-1];
                assign l_ent  = cell_ent[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_ent = cell_ent[gi];
            end
            else
            begin : g_mid
                assign r_ent = cell_ent[gi+1];
            end

            skvwb_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (cell_occ[gi]),
                .left_less (l_less),
                .left_ent  (l_ent),
                .right_ent (r_ent),
                .ent       (cell_ent[gi]),
                .hit_ent   (cell_hit[gi]),
                .less      (cell_less[gi]),
                .eq        (cell_eq[gi])
            );
        end
    endgenerate

    // at most one cell matches, so the hit entry is a plain or of the cells
    always_comb
    begin
        hit_ent = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_ent = hit_ent | cell_hit[i];
        end
    end
    assign hit = |cell_eq;

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_ent_next    = out_ent_reg;
        out_total_next  = out_total_reg;
        out_full_next   = out_full_reg;
        out_last_next   = 1'b1;
        ctrl.op         = CELL_HOLD;
        ctrl.req        = req_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (s_tuser) inside
                        REQ_PUT, REQ_GET:
                        begin
                            state_next = S_LOOK;
                        end
                        REQ_DRAIN:
                        begin
                            // the count empties at once, the cells drain after
                            state_next = S_DRAIN;
                            rem_next   = count_reg;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                ctrl.op    = CELL_LOOK;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    out_ent_next   = '0;
                    out_ent_next.key = req_reg.key;
                    if (req_type_reg == REQ_PUT)
                    begin
                        if (hit)
                        begin
                            ctrl.op         = CELL_UPDATE;
                            out_status_next = STS_UPDATED;
                            out_ent_next    = req_reg;
                        end
                        else if (at_limit)
                        begin
                            out_status_next = STS_REJECTED;
                        end
                        else
                        begin
                            ctrl.op         = CELL_INSERT;
                            count_next      = count_reg + 1'b1;
                            out_status_next = STS_INSERTED;
                            out_ent_next    = req_reg;
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            out_status_next      = hit_ent.tomb ? STS_TOMB : STS_LIVE;
                            out_ent_next.value   = hit_ent.value;
                            out_ent_next.tomb    = hit_ent.tomb;
                        end
                        else
                        begin
                            out_status_next = STS_MISS;
                        end
                    end
                    out_total_next = TOTAL_W'(count_next);
                    out_full_next  = (TOTAL_W'(count_next) >= eff_limit);
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_total_next = '0;
                    out_full_next  = (eff_limit == '0);
                    if (rem_reg == '0)
                    begin
                        out_status_next = STS_EMPTY;
                        out_ent_next    = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        // the head cell goes out, the rest shift left
                        ctrl.op         = CELL_DRAIN;
                        out_status_next = STS_DRAINED;
                        out_ent_next    = cell_ent[0];
                        out_last_next   = (rem_reg == CNT_W'(1));
                        rem_next        = rem_reg - 1'b1;
                        if (rem_reg == CNT_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
            fill_limit_reg <= FILL_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                fill_limit_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_type_reg  <= s_tuser;
            req_reg.key   <= s_tdata[63:0];
            req_reg.value <= s_tdata[127:64];
            req_reg.tomb  <= s_tdata[128];
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_ent_reg    <= out_ent_next;
            out_total_reg  <= out_total_next;
            out_full_reg   <= out_full_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_full_reg, out_total_reg, out_ent_reg.tomb,
                       out_ent_reg.value, out_ent_reg.key};

    // ---------------------------------------------------------------- checks
    assign out_is_drain = out_valid_reg &&
                          (out_status_reg == STS_DRAINED || out_status_reg == STS_EMPTY);
    assign act_stalled  = (state_reg == S_ACT) && !out_free;
    assign drain_moves  = (state_reg == S_DRAIN) && out_free && (rem_reg != '0);

`include "sorted_key_value_write_buffer_defines.svh"

    `SKVWB_ASSERT_ALWAYS(a_count_cap, count_reg <= CNT_W'(CAPACITY), "count beyond capacity")
    `SKVWB_ASSERT_IMPL(a_drain_empties, out_is_drain, count_reg == '0, "count kept on drain")
    `SKVWB_ASSERT_NEXT(a_act_stall, act_stalled, state_reg == S_ACT && count_reg == $past(count_reg), "result stage moved")
    `SKVWB_ASSERT_NEXT(a_drain_step, drain_moves, rem_reg == CNT_W'($past(rem_reg) - 1'b1), "drain skipped")

endmodule

>>> tb/tb_sorted_key_value_write_buffer.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_value_write_buffer
// drives put, get, drain and unknown requests into the write buffer and checks
// every result transfer against a mirror of the sorted entries, under several
// fill limits, sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_sorted_key_value_write_buffer;

    import skvwb_pkg::*;

    // request code the buffer must drop without a result
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // cycles allowed after the last due result before touching the register
    localparam int QUIET_CYCLES = 8;
    // hard stop, far above the slowest correct run
    localparam int RUN_LIMIT    = 3_000_000;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] key;
        logic [63:0] value;
        logic        tomb;
        logic [6:0]  total;
        logic        full;
        logic        last;
    } buffer_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // key[63:0], value[127:64], tombstone[128], zero pad
    logic [1:0]   s_tuser;   // req_type
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;   // out_key[63:0], out_value[127:64], out_tombstone[128],
                             // entry_total[135:129], is_full[136], zero pad
    logic [2:0]   m_tuser;   // status
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [6:0]   cfg_data;

    // mirror of the buffer contents, kept in ascending signed key order
    logic signed [63:0] mirror_keys [CAPACITY];
    logic signed [63:0] mirror_values [CAPACITY];
    logic               mirror_tombs [CAPACITY];
    int                 mirror_count;
    int                 mirror_limit;

    buffer_result_t due_results [$];
    logic [63:0]    key_pool [$];

    int  fail_count;
    int  burst_left;
    int  stall_left;
    bit  sender_gaps;
    bit  receiver_stalls;

    sorted_key_value_write_buffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // mirror of the buffer
    // ------------------------------------------------------------------------

    // result fields common to every step: count and full flag after the step
    function automatic buffer_result_t make_result(logic [2:0] status, logic [63:0] k,
                                                   logic [63:0] v, logic t, logic last);
        buffer_result_t r;
        int eff;
        eff = (mirror_limit < CAPACITY) ? mirror_limit : CAPACITY;
        r.status = status;
        r.key    = k;
        r.value  = v;
        r.tomb   = t;
        r.total  = 7'(mirror_count);
        r.full   = (mirror_count >= eff);
        r.last   = last;
        return r;
    endfunction

    // append one result to the list of those still due
    function automatic void queue_result(buffer_result_t r);
        due_results = {due_results, r};
    endfunction

    // apply one accepted request to the mirror and queue the results it causes
    function automatic void predict_buffer_request(logic [1:0] req, logic signed [63:0] k,
                                                   logic signed [63:0] v, logic t);
        int pos;
        int eff;
        int n;
        bit held;
        eff = (mirror_limit < CAPACITY) ? mirror_limit : CAPACITY;
        pos = 0;
        while (pos < mirror_count && mirror_keys[pos] < k)
            pos++;
        held = (pos < mirror_count) && (mirror_keys[pos] == k);
        case (req)
            REQ_PUT:
            begin
                if (held)
                begin
                    // update stays allowed even when the buffer is full
                    mirror_values[pos] = v;
                    mirror_tombs[pos]  = t;
                    queue_result(make_result(STS_UPDATED, k, v, t, 1'b1));
                end
                else if (mirror_count >= eff)
                begin
                    queue_result(make_result(STS_REJECTED, k, '0, 1'b0, 1'b1));
                end
                else
                begin
                    for (int i = mirror_count; i > pos; i--)
                    begin
                        mirror_keys[i]   = mirror_keys[i-1];
                        mirror_values[i] = mirror_values[i-1];
                        mirror_tombs[i]  = mirror_tombs[i-1];
                    end
                    mirror_keys[pos]   = k;
                    mirror_values[pos] = v;
                    mirror_tombs[pos]  = t;
                    mirror_count++;
                    queue_result(make_result(STS_INSERTED, k, v, t, 1'b1));
                end
            end
            REQ_GET:
            begin
                if (!held)
                    queue_result(make_result(STS_MISS, k, '0, 1'b0, 1'b1));
                else if (mirror_tombs[pos])
                    queue_result(make_result(STS_TOMB, k, mirror_values[pos],
                                             1'b1, 1'b1));
                else
                    queue_result(make_result(STS_LIVE, k, mirror_values[pos],
                                             1'b0, 1'b1));
            end
            REQ_DRAIN:
            begin
                // the count reads zero on every drained entry
                n = mirror_count;
                mirror_count = 0;
                if (n == 0)
                    queue_result(make_result(STS_EMPTY, '0, '0, 1'b0, 1'b1));
                for (int i = 0; i < n; i++)
                    queue_result(make_result(STS_DRAINED, mirror_keys[i],
                                             mirror_values[i], mirror_tombs[i],
                                             i == n - 1));
            end
            default:
            begin
                // unknown request: no state change, no result
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        buffer_result_t got;
        buffer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.key    = m_tdata[63:0];
            got.value  = m_tdata[127:64];
            got.tomb   = m_tdata[128];
            got.total  = m_tdata[135:129];
            got.full   = m_tdata[136];
            got.last   = m_tlast;
            if (due_results.size() == 0)
            begin
                report_mismatch("result transfer with none due, status", got.status, '0);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.key !== want.key)       report_mismatch("out_key", got.key, want.key);
                if (got.value !== want.value)   report_mismatch("out_value", got.value, want.value);
                if (got.tomb !== want.tomb)     report_mismatch("out_tombstone", got.tomb, want.tomb);
                if (got.total !== want.total)   report_mismatch("entry_total", got.total, want.total);
                if (got.full !== want.full)     report_mismatch("is_full", got.full, want.full);
                if (got.last !== want.last)     report_mismatch("last", got.last, want.last);
            end
        end
    end

    // receiver: random stalls while enabled
    initial
    begin
        m_tready = 1'b1;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (receiver_stalls && $urandom_range(0, 9) < 3)
                    stall_left = $urandom_range(1, 6);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one request transfer; the sender runs in bursts with gaps between them
    task automatic send_request(input logic [1:0] req, input logic [63:0] k,
                                input logic [63:0] v, input logic t);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 8);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, t, v, k};
        do
            @(posedge clk);
        while (!s_tready);
        predict_buffer_request(req, k, v, t);
        if (req == REQ_PUT)
        begin
            key_pool = {key_pool, k};
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
    endtask

    // hold the sender until every due result has come, then let the block settle
    task automatic wait_until_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_fill_limit(input logic [6:0] limit);
        wait_until_quiet();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror_limit = limit;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // keys often reuse recent ones so that updates and hits happen
    function automatic logic [63:0] random_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (roll < 70)
            return 64'($signed($urandom_range(0, 40)) - 20);
        return random_word();
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every request kind with the key and value extremes
    task automatic test_basic_requests();
        send_request(REQ_GET, 64'sd5, '0, 1'b0);                // miss on empty buffer
        send_request(REQ_DRAIN, '0, '0, 1'b0);                  // drain of empty buffer
        send_request(REQ_PUT, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0);
        send_request(REQ_PUT, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 1'b1);
        send_request(REQ_PUT, '0, '0, 1'b0);
        send_request(REQ_PUT, '1, '1, 1'b1);
        send_request(REQ_PUT, '0, 64'd1, 1'b1);                 // update of a held key
        send_request(REQ_GET, 64'h8000_0000_0000_0000, '0, 1'b1);
        send_request(REQ_GET, 64'h7fff_ffff_ffff_ffff, '1, 1'b0);
        send_request(REQ_GET, 64'd1, '0, 1'b0);
        send_request(REQ_UNKNOWN, random_word(), random_word(), 1'b1);
        send_request(REQ_DRAIN, random_word(), random_word(), 1'b1);
        send_request(REQ_GET, '0, '0, 1'b0);
    endtask

    // full flag, rejection, update while full and the zero limit
    task automatic test_fill_limits();
        write_fill_limit(7'd1);
        send_request(REQ_PUT, 64'sd10, random_word(), 1'b0);
        send_request(REQ_PUT, 64'sd11, random_word(), 1'b0);    // refused, buffer full
        send_request(REQ_PUT, 64'sd10, random_word(), 1'b1);    // held key still updates
        send_request(REQ_GET, 64'sd11, '0, 1'b0);
        send_request(REQ_DRAIN, '0, '0, 1'b0);
        // zero limit: always full, every new key refused
        write_fill_limit(7'd0);
        send_request(REQ_PUT, 64'sd7, random_word(), 1'b1);
        send_request(REQ_GET, 64'sd7, '0, 1'b0);
        send_request(REQ_DRAIN, '0, '0, 1'b0);
    endtask

    // random traffic under one limit, with a pause for all results halfway
    task automatic test_random_traffic(input logic [6:0] limit, input int items,
                                       input int put_share);
        int roll;
        logic [1:0] req;
        write_fill_limit(limit);
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
                wait_until_quiet();
            roll = $urandom_range(0, 99);
            if (roll < put_share)
                req = REQ_PUT;
            else if (roll < 90)
                req = REQ_GET;
            else if (roll < 96)
                req = REQ_DRAIN;
            else
                req = REQ_UNKNOWN;
            send_request(req, random_key(), random_word(), 1'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_PUT;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        fail_count   = 0;
        burst_left   = 0;
        sender_gaps  = 1'b1;
        receiver_stalls = 1'b1;
        mirror_count = 0;
        mirror_limit = FILL_LIMIT_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_requests();
        test_fill_limits();
        // limit above the capacity: the capacity itself bounds the fill
        test_random_traffic(7'd64, 40, 80);
        test_random_traffic(7'($urandom_range(1, 64)), 25, 55);
        test_random_traffic(7'd3, 25, 55);
        // a stretch with neither gaps nor stalls
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        test_random_traffic(FILL_LIMIT_RESET, 25, 60);

        wait_until_quiet();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/skvwb_pkg.sv
rtl/skvwb_cell.sv
rtl/sorted_key_value_write_buffer.sv
tb/tb_sorted_key_value_write_buffer.sv
